// ===== hdl/pfs_pkg.sv =====
package pfs_pkg;

  // Ring geometry; FRAMES must be a power of two
  localparam int FRAMES = 128;
  localparam int FLOWS  = 2;
  localparam int FW     = $clog2(FRAMES);
  localparam int AW     = FW + 1;
  localparam int CNT_W  = FW + 1;

  // Field widths
  localparam int SEQ_W  = 31;
  localparam int TIME_W = 32;
  localparam int SIZE_W = 16;
  localparam int CHK_W  = 8;
  localparam int STAT_W = 32;
  localparam int FRAC_W = 16;

  // Scan accumulators
  localparam int BACC_W = SIZE_W + FW;
  localparam int CACC_W = CHK_W + FW;
  localparam int LACC_W = TIME_W + FW;

  // Rate scale: 1e6 us per second times 256 for 8 fraction bits
  localparam int RSC_W  = 28;
  localparam logic [RSC_W-1:0] RATE_SCALE = RSC_W'(256000000);
  localparam int PROD_W = BACC_W + RSC_W;

  // Shared divider
  localparam int DIV_NW = PROD_W;
  localparam int DIV_DW = 32;
  localparam int DIV_CW = $clog2(DIV_NW + 1);

  // Loss / choke numerator
  localparam int LN_W   = 40;

  localparam logic [31:0] INTERVAL_RST = 32'd250000;

  localparam logic OP_PACKET = 1'b0;
  localparam logic OP_UPDATE = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_NEW,
    ST_GAP,
    ST_WRITE,
    ST_ACK_RD,
    ST_ACK_UPD,
    ST_UPD,
    ST_SCAN,
    ST_SCAN_END,
    ST_EVAL,
    ST_MUL,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_FIN,
    ST_RESULT
  } state_t;

  typedef enum logic [1:0] {
    PH_BYTE,
    PH_PKT,
    PH_LAT
  } phase_t;

  typedef struct packed {
    logic [TIME_W-1:0] time_us;
    logic [SIZE_W-1:0] size;
    logic [CHK_W-1:0]  choked;
    logic              acked;
    logic [TIME_W-1:0] latency;
  } frame_t;

  typedef struct packed {
    logic          wr_en;
    logic          set_vld;
    logic          clr_vld;
    logic [AW-1:0] wr_addr;
    frame_t        wr_data;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
  } mem_cmd_t;

  typedef struct packed {
    logic              op;
    logic              flow;
    logic [SEQ_W-1:0]  seq_nr;
    logic [SEQ_W-1:0]  ack_nr;
    logic [CHK_W-1:0]  choked_count;
    logic [SIZE_W-1:0] packet_size;
    logic [SIZE_W-1:0] added_bytes;
    logic [TIME_W-1:0] now_us;
  } item_t;

  typedef struct packed {
    logic              recomputed;
    logic [STAT_W-1:0] avg_byte_rate;
    logic [STAT_W-1:0] avg_packet_rate;
    logic [FRAC_W-1:0] avg_loss_frac;
    logic [FRAC_W-1:0] avg_choke_frac;
    logic [STAT_W-1:0] last_latency_us;
    logic [STAT_W-1:0] avg_latency_us;
    logic [STAT_W-1:0] packet_total;
    logic [STAT_W-1:0] byte_total;
  } result_t;

endpackage

// ===== hdl/pfs_div.sv =====
module pfs_div import pfs_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [DIV_NW-1:0] dividend,
  input  logic [DIV_DW-1:0] divisor,
  output logic              done,
  output logic [DIV_NW-1:0] quotient
);

  logic [DIV_NW-1:0] quo_r;
  logic [DIV_DW:0]   rem_r;
  logic [DIV_DW-1:0] dvs_r;
  logic [DIV_CW-1:0] cnt_r;
  logic              busy_r;
  logic              done_r;
  logic [DIV_DW:0]   rem_sh;
  logic [DIV_DW+1:0] diff;
  logic              ge;

  // One restoring step: shift in next dividend bit, try subtract
  always_comb begin
    rem_sh = {rem_r[DIV_DW-1:0], quo_r[DIV_NW-1]};
    diff   = {1'b0, rem_sh} - {2'b00, dvs_r};
    ge     = ~diff[DIV_DW+1];
  end

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= DIV_CW'(DIV_NW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == DIV_CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      rem_r <= ge ? diff[DIV_DW:0] : rem_sh;
      quo_r <= {quo_r[DIV_NW-2:0], ge};
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// ===== hdl/pfs_frame_mem.sv =====
module pfs_frame_mem import pfs_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  mem_cmd_t cmd,
  output frame_t   rd_data,
  output logic     rd_vld
);

  localparam int DEPTH = FRAMES * FLOWS;

  frame_t             mem [DEPTH];
  logic [DEPTH-1:0]   vld_r;
  frame_t             rd_data_r;
  logic               rd_vld_r;

  // Frame records: one write, one registered read
  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[cmd.wr_addr] <= cmd.wr_data;
    end
    if (cmd.rd_en) begin
      rd_data_r <= mem[cmd.rd_addr];
    end
  end

  // Valid bits, cleared at reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (cmd.clr_vld) begin
        vld_r[cmd.wr_addr] <= 1'b0;
      end else if (cmd.wr_en && cmd.set_vld) begin
        vld_r[cmd.wr_addr] <= 1'b1;
      end
      if (cmd.rd_en) begin
        rd_vld_r <= vld_r[cmd.rd_addr];
      end
    end
  end

  assign rd_data = rd_data_r;
  assign rd_vld  = rd_vld_r;

endmodule

// ===== hdl/pfs_ctrl.sv =====
module pfs_ctrl import pfs_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [31:0] interval,
  input  logic        item_valid,
  input  item_t       item,
  output logic        item_ready,
  output logic        res_valid,
  input  logic        res_take,
  output result_t     res
);

  state_t state_r, state_nxt;
  phase_t phase_r;

  // Captured word
  logic              flow_r;
  logic [SEQ_W-1:0]  seq_r;
  logic [SEQ_W-1:0]  ack_r;
  logic [CHK_W-1:0]  choked_r;
  logic [SIZE_W-1:0] size_r;
  logic [SIZE_W-1:0] added_r;
  logic [TIME_W-1:0] now_r;
  logic              rec_r;

  // Per-flow state
  logic [SEQ_W-1:0]  cur_seq_r   [FLOWS];
  logic [TIME_W-1:0] next_time_r [FLOWS];
  logic [STAT_W-1:0] pkts_r      [FLOWS];
  logic [STAT_W-1:0] bytes_r     [FLOWS];
  logic [STAT_W-1:0] brate_r     [FLOWS];
  logic [STAT_W-1:0] prate_r     [FLOWS];
  logic [FRAC_W-1:0] loss_r      [FLOWS];
  logic [FRAC_W-1:0] choke_r     [FLOWS];
  logic [STAT_W-1:0] rlat_r      [FLOWS];
  logic [STAT_W-1:0] slat_r      [FLOWS];

  // Walk and scan
  logic [FW-1:0]     idx_r;
  logic [FW-1:0]     cnt_r;
  logic              acc_en_r;
  logic [CNT_W-1:0]  nvalid_r;
  logic [BACC_W-1:0] nbytes_r;
  logic [CACC_W-1:0] nchoked_r;
  logic [LACC_W-1:0] lat_sum_r;
  logic [CNT_W-1:0]  lat_cnt_r;
  logic [TIME_W-1:0] tmin_r;
  logic [TIME_W-1:0] tmax_r;
  logic [PROD_W-1:0] prod_r;

  mem_cmd_t          cmd;
  frame_t            rd_data;
  logic              rd_vld;
  logic              div_start;
  logic              div_done;
  logic [DIV_NW-1:0] div_dividend;
  logic [DIV_DW-1:0] div_divisor;
  logic [DIV_NW-1:0] div_q;

  // Derived values
  logic              cs_idx;
  logic [SEQ_W-1:0]  cur_sel;
  logic              seq_ahead;
  logic [SEQ_W-1:0]  seq_diff;
  logic              big_gap;
  logic [FW-1:0]     gap_cnt;
  logic [SEQ_W-1:0]  start_seq;
  logic              ack_stale;
  logic              rate_ok;
  logic [TIME_W-1:0] span;
  logic [STAT_W-1:0] sample;
  logic [STAT_W-1:0] old_sel;
  logic [STAT_W+1:0] smooth_sum;
  logic [STAT_W-1:0] smoothed;
  logic [BACC_W-1:0] mul_a;
  logic [TIME_W-1:0] lat_val;
  logic [CNT_W-1:0]  ninvalid;
  logic [LN_W-1:0]   loss_num;
  logic [LN_W-1:0]   choke_num;
  logic [LN_W-1:0]   loss_q;
  logic [LN_W-1:0]   choke_q;
  logic [FRAC_W-1:0] loss_new;
  logic [FRAC_W-1:0] choke_new;

  pfs_frame_mem u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (cmd),
    .rd_data (rd_data),
    .rd_vld  (rd_vld)
  );

  pfs_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_q)
  );

  // Sequence bookkeeping
  always_comb begin
    cs_idx    = (state_r == ST_ACK_RD) ? ~flow_r : flow_r;
    cur_sel   = cur_seq_r[cs_idx];
    seq_ahead = seq_r > cur_sel;
    seq_diff  = seq_r - cur_sel;
    big_gap   = seq_diff > SEQ_W'(FRAMES);
    start_seq = big_gap ? (seq_r - SEQ_W'(FRAMES - 1)) : (cur_sel + 1'b1);
    gap_cnt   = big_gap ? FW'(FRAMES - 1) : FW'(seq_diff - 1'b1);
    ack_stale = ({1'b0, ack_r} + 32'(FRAMES)) <= {1'b0, cur_sel};
    lat_val   = (now_r >= rd_data.time_us) ? (now_r - rd_data.time_us) : '0;
  end

  // Rate and smoothing arithmetic
  always_comb begin
    rate_ok    = (nvalid_r != '0) && (tmax_r > tmin_r);
    span       = tmax_r - tmin_r;
    mul_a      = (phase_r == PH_BYTE) ? nbytes_r : BACC_W'(nvalid_r);
    sample     = (|div_q[DIV_NW-1:STAT_W]) ? '1 : div_q[STAT_W-1:0];
    unique case (phase_r)
      PH_BYTE: old_sel = brate_r[flow_r];
      PH_PKT:  old_sel = prate_r[flow_r];
      default: old_sel = slat_r[flow_r];
    endcase
    smooth_sum = {2'b00, old_sel} + {1'b0, old_sel, 1'b0} + {2'b00, sample};
    smoothed   = smooth_sum[STAT_W+1:2];
    if (phase_r == PH_LAT) begin
      div_dividend = DIV_NW'(lat_sum_r);
      div_divisor  = DIV_DW'(lat_cnt_r);
    end else begin
      div_dividend = prod_r;
      div_divisor  = span;
    end
  end

  // Loss and choke averages
  always_comb begin
    ninvalid  = CNT_W'(FRAMES) - nvalid_r;
    loss_num  = ((LN_W'(loss_r[flow_r]) * LN_W'(3)) << FW)
              + ((LN_W'(ninvalid) - LN_W'(nchoked_r)) << FRAC_W);
    choke_num = ((LN_W'(choke_r[flow_r]) * LN_W'(3)) << FW)
              + (LN_W'(nchoked_r) << FRAC_W);
    loss_q    = loss_num >> (FW + 2);
    choke_q   = choke_num >> (FW + 2);
    if (loss_num[LN_W-1]) begin
      loss_new = '0;
    end else if (|loss_q[LN_W-1:FRAC_W]) begin
      loss_new = '1;
    end else begin
      loss_new = loss_q[FRAC_W-1:0];
    end
    choke_new = (|choke_q[LN_W-1:FRAC_W]) ? '1 : choke_q[FRAC_W-1:0];
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:     if (item_valid) begin
                     state_nxt = (item.op == OP_PACKET) ? ST_NEW : ST_UPD;
                   end
      ST_NEW:      begin
                     if (!seq_ahead) state_nxt = ST_ACK_RD;
                     else if (gap_cnt == '0) state_nxt = ST_WRITE;
                     else state_nxt = ST_GAP;
                   end
      ST_GAP:      if (cnt_r == FW'(1)) state_nxt = ST_WRITE;
      ST_WRITE:    state_nxt = ST_ACK_RD;
      ST_ACK_RD:   state_nxt = ack_stale ? ST_RESULT : ST_ACK_UPD;
      ST_ACK_UPD:  state_nxt = ST_RESULT;
      ST_UPD:      state_nxt = (next_time_r[flow_r] > now_r) ? ST_RESULT : ST_SCAN;
      ST_SCAN:     if (idx_r == FW'(FRAMES - 1)) state_nxt = ST_SCAN_END;
      ST_SCAN_END: state_nxt = ST_EVAL;
      ST_EVAL:     begin
                     if (rate_ok) state_nxt = ST_MUL;
                     else if (lat_cnt_r != '0) state_nxt = ST_DIV_GO;
                     else state_nxt = ST_FIN;
                   end
      ST_MUL:      state_nxt = ST_DIV_GO;
      ST_DIV_GO:   state_nxt = ST_DIV_WAIT;
      ST_DIV_WAIT: if (div_done) begin
                     unique case (phase_r)
                       PH_BYTE: state_nxt = ST_MUL;
                       PH_PKT:  state_nxt = (lat_cnt_r != '0) ? ST_DIV_GO : ST_FIN;
                       default: state_nxt = ST_FIN;
                     endcase
                   end
      ST_FIN:      state_nxt = ST_RESULT;
      ST_RESULT:   if (res_take) state_nxt = ST_IDLE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  // Outputs: memory commands, divider start, handshakes
  always_comb begin
    cmd         = '0;
    item_ready  = 1'b0;
    res_valid   = 1'b0;
    div_start   = 1'b0;
    unique case (state_r)
      ST_IDLE:     item_ready = 1'b1;
      ST_GAP:      begin
                     cmd.clr_vld = 1'b1;
                     cmd.wr_addr = {flow_r, idx_r};
                   end
      ST_WRITE:    begin
                     cmd.wr_en           = 1'b1;
                     cmd.set_vld         = 1'b1;
                     cmd.wr_addr         = {flow_r, seq_r[FW-1:0]};
                     cmd.wr_data.time_us = now_r;
                     cmd.wr_data.size    = size_r;
                     cmd.wr_data.choked  = choked_r;
                     cmd.wr_data.acked   = 1'b0;
                     cmd.wr_data.latency = '0;
                   end
      ST_ACK_RD:   begin
                     cmd.rd_en   = ~ack_stale;
                     cmd.rd_addr = {~flow_r, ack_r[FW-1:0]};
                   end
      ST_ACK_UPD:  begin
                     cmd.wr_en           = rd_vld & ~rd_data.acked;
                     cmd.wr_addr         = {~flow_r, ack_r[FW-1:0]};
                     cmd.wr_data         = rd_data;
                     cmd.wr_data.acked   = 1'b1;
                     cmd.wr_data.latency = lat_val;
                   end
      ST_SCAN:     begin
                     cmd.rd_en   = 1'b1;
                     cmd.rd_addr = {flow_r, idx_r};
                   end
      ST_DIV_GO:   div_start = 1'b1;
      ST_RESULT:   res_valid = 1'b1;
      default:     cmd = '0;
    endcase
  end

  // Advance state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      acc_en_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      acc_en_r <= (state_r == ST_SCAN);
    end
  end

  // Per-flow statistics
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int f = 0; f < FLOWS; f++) begin
        cur_seq_r[f]   <= '0;
        next_time_r[f] <= '0;
        pkts_r[f]      <= '0;
        bytes_r[f]     <= '0;
        brate_r[f]     <= '0;
        prate_r[f]     <= '0;
        loss_r[f]      <= '0;
        choke_r[f]     <= '0;
        rlat_r[f]      <= '0;
        slat_r[f]      <= '0;
      end
    end else begin
      unique case (state_r)
        ST_NEW:      begin
                       pkts_r[flow_r]    <= pkts_r[flow_r] + 1'b1;
                       cur_seq_r[flow_r] <= seq_r;
                     end
        ST_UPD:      begin
                       bytes_r[flow_r] <= bytes_r[flow_r] + STAT_W'(added_r);
                       if (next_time_r[flow_r] <= now_r) begin
                         next_time_r[flow_r] <= now_r + interval;
                       end
                     end
        ST_DIV_WAIT: if (div_done) begin
                       unique case (phase_r)
                         PH_BYTE: brate_r[flow_r] <= smoothed;
                         PH_PKT:  prate_r[flow_r] <= smoothed;
                         default: begin
                                    rlat_r[flow_r] <= div_q[STAT_W-1:0];
                                    slat_r[flow_r] <= smoothed;
                                  end
                       endcase
                     end
        ST_FIN:      begin
                       loss_r[flow_r]  <= loss_new;
                       choke_r[flow_r] <= choke_new;
                     end
        default:     ;
      endcase
    end
  end

  // Working registers: captured word, walk pointers, scan sums
  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && item_valid) begin
      flow_r   <= item.flow;
      seq_r    <= item.seq_nr;
      ack_r    <= item.ack_nr;
      choked_r <= item.choked_count;
      size_r   <= item.packet_size;
      added_r  <= item.added_bytes;
      now_r    <= item.now_us;
      rec_r    <= 1'b0;
    end
    if (state_r == ST_NEW) begin
      idx_r <= start_seq[FW-1:0];
      cnt_r <= gap_cnt;
    end
    if (state_r == ST_GAP) begin
      idx_r <= idx_r + 1'b1;
      cnt_r <= cnt_r - 1'b1;
    end
    if (state_r == ST_UPD) begin
      idx_r     <= '0;
      nvalid_r  <= '0;
      nbytes_r  <= '0;
      nchoked_r <= '0;
      lat_sum_r <= '0;
      lat_cnt_r <= '0;
      tmin_r    <= '1;
      tmax_r    <= '0;
      rec_r     <= (next_time_r[flow_r] <= now_r);
    end
    if (state_r == ST_SCAN) begin
      idx_r <= idx_r + 1'b1;
    end
    // Accumulate one frame per cycle, in the cycle after its read is issued
    if (acc_en_r && rd_vld) begin
      if (rd_data.time_us < tmin_r) tmin_r <= rd_data.time_us;
      if (rd_data.time_us > tmax_r) tmax_r <= rd_data.time_us;
      nvalid_r  <= nvalid_r + 1'b1;
      nbytes_r  <= nbytes_r + BACC_W'(rd_data.size);
      nchoked_r <= nchoked_r + CACC_W'(rd_data.choked);
      if (rd_data.acked) begin
        lat_sum_r <= lat_sum_r + LACC_W'(rd_data.latency);
        lat_cnt_r <= lat_cnt_r + 1'b1;
      end
    end
    if (state_r == ST_EVAL) begin
      phase_r <= rate_ok ? PH_BYTE : PH_LAT;
    end
    if (state_r == ST_MUL) begin
      prod_r <= mul_a * RATE_SCALE;
    end
    if (state_r == ST_DIV_WAIT && div_done) begin
      if (phase_r == PH_BYTE) phase_r <= PH_PKT;
      else phase_r <= PH_LAT;
    end
  end

  // Result word for the selected flow
  always_comb begin
    res.recomputed      = rec_r;
    res.avg_byte_rate   = brate_r[flow_r];
    res.avg_packet_rate = prate_r[flow_r];
    res.avg_loss_frac   = loss_r[flow_r];
    res.avg_choke_frac  = choke_r[flow_r];
    res.last_latency_us = rlat_r[flow_r];
    res.avg_latency_us  = slat_r[flow_r];
    res.packet_total    = pkts_r[flow_r];
    res.byte_total      = bytes_r[flow_r];
  end

endmodule

// ===== hdl/packet_flow_statistics.sv =====
// Channel   Direction  Handshake         Payload
// cfg       in         cfg_wr_en         cfg_wr_data (compute interval, us)
// in        in         in_valid/in_stall op, flow, seq/ack numbers, sizes, time
// out       out        out_valid/out_stall recomputed flag and flow statistics
//
// One word at a time: a new word is accepted only in idle, once the last result is taken.
// A new packet ahead of the current sequence number has the gap walk clear one frame valid
// bit per cycle, then one write; each packet then does an ack read-modify-write unless the
// ack is stale. An update without recompute only adds bytes; a recompute scans all FRAMES
// records, then runs up to three 51-step divisions on the shared divider.
// Synchronous reset clears frame valid bits and flow statistics; a result waits in the
// output register while out_stall is high.
module packet_flow_statistics import pfs_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic [31:0]       cfg_wr_data,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_op,
  input  logic              in_flow,
  input  logic [SEQ_W-1:0]  in_seq_nr,
  input  logic [SEQ_W-1:0]  in_ack_nr,
  input  logic [CHK_W-1:0]  in_choked_count,
  input  logic [SIZE_W-1:0] in_packet_size,
  input  logic [SIZE_W-1:0] in_added_bytes,
  input  logic [TIME_W-1:0] in_now_us,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              out_recomputed,
  output logic [STAT_W-1:0] out_avg_byte_rate,
  output logic [STAT_W-1:0] out_avg_packet_rate,
  output logic [FRAC_W-1:0] out_avg_loss_frac,
  output logic [FRAC_W-1:0] out_avg_choke_frac,
  output logic [STAT_W-1:0] out_last_latency_us,
  output logic [STAT_W-1:0] out_avg_latency_us,
  output logic [STAT_W-1:0] out_packet_total,
  output logic [STAT_W-1:0] out_byte_total
);

  logic [31:0] interval_r;
  item_t       item;
  logic        item_ready;
  logic        res_valid;
  logic        res_take;
  result_t     res;
  result_t     out_r;
  logic        out_valid_r;

  // Hold the compute interval
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      interval_r <= INTERVAL_RST;
    end else if (cfg_wr_en) begin
      interval_r <= cfg_wr_data;
    end
  end

  // Pack the input word
  always_comb begin
    item.op           = in_op;
    item.flow         = in_flow;
    item.seq_nr       = in_seq_nr;
    item.ack_nr       = in_ack_nr;
    item.choked_count = in_choked_count;
    item.packet_size  = in_packet_size;
    item.added_bytes  = in_added_bytes;
    item.now_us       = in_now_us;
  end

  assign in_stall = ~item_ready;

  pfs_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .interval   (interval_r),
    .item_valid (in_valid),
    .item       (item),
    .item_ready (item_ready),
    .res_valid  (res_valid),
    .res_take   (res_take),
    .res        (res)
  );

  // Output register: load when empty or being drained
  assign res_take = res_valid & (~out_valid_r | ~out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_take) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_r <= res;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_recomputed      = out_r.recomputed;
  assign out_avg_byte_rate   = out_r.avg_byte_rate;
  assign out_avg_packet_rate = out_r.avg_packet_rate;
  assign out_avg_loss_frac   = out_r.avg_loss_frac;
  assign out_avg_choke_frac  = out_r.avg_choke_frac;
  assign out_last_latency_us = out_r.last_latency_us;
  assign out_avg_latency_us  = out_r.avg_latency_us;
  assign out_packet_total    = out_r.packet_total;
  assign out_byte_total      = out_r.byte_total;

endmodule
